// ===== rtl/tocr_pkg.sv =====
// Shared types and constants of the text overlay cell renderer.
package tocr_pkg;

   typedef enum logic [1:0] {
      REQ_CELL_WRITE = 2'd0,
      REQ_FONT_WRITE = 2'd1,
      REQ_RENDER     = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_OVERLAY_ENABLED = 2'd0,
      CSR_FONT_FIRST_CODE = 2'd1,
      CSR_FONT_LAST_CODE  = 2'd2
   } csr_index_type;

   localparam int CELL_PIXELS = 8;
   localparam int COLOUR_W    = 6;
   localparam int PIXELS_W    = CELL_PIXELS * COLOUR_W;
   localparam int PIXEL_X_W   = 8;
   localparam int CODE_W      = 8;
   localparam int PAL_W       = 2;
   localparam int CELL_DATA_W = CODE_W + PAL_W;
   localparam int FWORD_W     = 16;

   // Row of the text buffer and row inside the glyph for an 8-bit line.
   localparam int ROW_W       = 5;
   localparam int SUB_W       = 4;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = 22;

   // Working widths for cell and font addresses.
   localparam int CALC_W      = 16;
   localparam int FADDR_W     = 14;

   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int OCC_W       = 4;

   localparam logic [CODE_W-1:0] FONT_FIRST_RESET = 8'd32;
   localparam logic [CODE_W-1:0] FONT_LAST_RESET  = 8'd255;

   // Colour of each pixel, indexed as palette * 4 + pixel code.
   localparam logic [COLOUR_W-1:0] COLOUR_TABLE [16] = '{
      6'h1D, 6'h00, 6'h10, 6'h20, 6'h21, 6'h11, 6'h01, 6'h3F,
      6'h2D, 6'h00, 6'h10, 6'h3D, 6'h3F, 6'h1C, 6'h2C, 6'h3C
   };

   typedef struct packed {
      logic [PIXELS_W-1:0]  pixels;
      logic                 draw;
      logic [PIXEL_X_W-1:0] pixel_x;
      logic                 frame_end;
   } rsp_item_type;

endpackage

// ===== rtl/text_overlay_cell_renderer.sv =====
// Text overlay cell renderer: cell and font stores with a four-stage render pipeline.
//
// Accepts one item per clock while req_tready is high and returns one result per
// item, in order. Stage one divides the line to find the buffer row, stage two
// derives the glyph row and reads or writes the cell store (character code
// and palette), stage three reads or writes the font store, stage four maps the
// eight 2-bit pixels through the colour table into an 8-entry result queue;
// req_tready drops when eight items are in flight or queued. Each store
// has a single port used by one stage, so a write is seen by every later item.
// After reset a clearing pass zeroes the cell store, one cell a cycle, covering
// all (SCREEN_LINES/GLYPH_ROWS)*(SCREEN_PIXELS/8) cells (480 at the defaults);
// req_tready stays low meanwhile, register writes are taken. The font store is
// not cleared: load every glyph row before rendering codes that use it.
module text_overlay_cell_renderer #(
   parameter int SCREEN_LINES  = 240,
   parameter int SCREEN_PIXELS = 256,
   parameter int GLYPH_ROWS    = 16,
   parameter int FONT_WORDS    = 4096
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_index[8:0], char_code[16:9], palette_select[18:17], font_address[30:19],
   // font_word[46:31], line[54:47], column[59:55], zero[63:60]
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixels[47:0], pixel_x[55:48]
   output logic [55:0] rsp_tdata,
   // draw[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int BUF_COLS  = SCREEN_PIXELS / tocr_pkg::CELL_PIXELS;
   localparam int BUF_ROWS  = SCREEN_LINES / GLYPH_ROWS;
   localparam int BUF_CELLS = BUF_COLS * BUF_ROWS;
   localparam int CIDX_W    = $clog2(BUF_CELLS);
   localparam int FIDX_W    = $clog2(FONT_WORDS);
   localparam int ROW_RECIP = (2 ** tocr_pkg::RECIP_SHIFT + GLYPH_ROWS - 1) / GLYPH_ROWS;

   // configuration registers
   logic                        overlay_en_ff;
   logic [tocr_pkg::CODE_W-1:0] first_code_ff;
   logic [tocr_pkg::CODE_W-1:0] last_code_ff;
   logic                        csr_wr;

   // clearing pass
   logic              clr_busy_ff, clr_busy_in;
   logic [CIDX_W-1:0] clr_addr_ff, clr_addr_in;

   // input unpacking
   tocr_pkg::req_kind_type            req_kind;
   logic [8:0]                        req_cell_index;
   logic [tocr_pkg::CODE_W-1:0]       req_char_code;
   logic [tocr_pkg::PAL_W-1:0]        req_palette;
   logic [11:0]                       req_font_address;
   logic [tocr_pkg::FWORD_W-1:0]      req_font_word;
   logic [7:0]                        req_line;
   logic [4:0]                        req_column;
   logic                              req_accept;
   logic [tocr_pkg::PROD_W-1:0]       row_prod;

   // stage 1
   logic                              s1_vld_ff;
   tocr_pkg::req_kind_type            s1_kind_ff;
   logic [8:0]                        s1_cell_index_ff;
   logic [tocr_pkg::CODE_W-1:0]       s1_char_code_ff;
   logic [tocr_pkg::PAL_W-1:0]        s1_palette_ff;
   logic [11:0]                       s1_font_address_ff;
   logic [tocr_pkg::FWORD_W-1:0]      s1_font_word_ff;
   logic [7:0]                        s1_line_ff;
   logic [4:0]                        s1_column_ff;
   logic [tocr_pkg::ROW_W-1:0]        s1_row_ff, s1_row_in;

   // stage 2 and cell store
   logic [tocr_pkg::CALC_W-1:0]       render_cell;
   logic [7:0]                        row_base;
   logic [7:0]                        sub_full;
   logic                              render_ok;
   logic                              frame_end_hit;
   logic                              cell_we;
   logic                              cell_re;
   logic [CIDX_W-1:0]                 cell_addr;
   logic [tocr_pkg::CELL_DATA_W-1:0]  cell_wdata;
   logic [tocr_pkg::CELL_DATA_W-1:0]  cell_ram_ff [BUF_CELLS];
   logic [tocr_pkg::CELL_DATA_W-1:0]  cell_rd_ff;

   logic                              s2_vld_ff;
   tocr_pkg::req_kind_type            s2_kind_ff;
   logic [11:0]                       s2_font_address_ff;
   logic [tocr_pkg::FWORD_W-1:0]      s2_font_word_ff;
   logic [tocr_pkg::SUB_W-1:0]        s2_sub_ff, s2_sub_in;
   logic [4:0]                        s2_column_ff;
   logic                              s2_fend_ff, s2_fend_in;
   logic                              s2_render_ok_ff, s2_render_ok_in;

   // stage 3 and font store
   logic [tocr_pkg::CODE_W-1:0]       cell_code;
   logic [tocr_pkg::PAL_W-1:0]        cell_pal;
   logic                              code_ok;
   logic [tocr_pkg::CODE_W-1:0]       code_off;
   logic [tocr_pkg::FADDR_W-1:0]      glyph_addr;
   logic [tocr_pkg::FADDR_W-1:0]      load_addr;
   logic                              font_we;
   logic                              font_re;
   logic [FIDX_W-1:0]                 font_idx;
   logic [tocr_pkg::FWORD_W-1:0]      font_ram_ff [FONT_WORDS];
   logic [tocr_pkg::FWORD_W-1:0]      font_rd_ff;

   logic                              s3_vld_ff;
   tocr_pkg::req_kind_type            s3_kind_ff;
   logic                              s3_draw_ff, s3_draw_in;
   logic [tocr_pkg::PAL_W-1:0]        s3_pal_ff;
   logic [4:0]                        s3_column_ff;
   logic                              s3_fend_ff;

   // stage 4 and result queue
   logic [tocr_pkg::PIXELS_W-1:0]     mapped_pixels;
   tocr_pkg::rsp_item_type            rsp_item;
   tocr_pkg::rsp_item_type            fifo_ff [tocr_pkg::FIFO_DEPTH];
   tocr_pkg::rsp_item_type            fifo_head;
   logic [tocr_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tocr_pkg::FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tocr_pkg::OCC_W-1:0]        fifo_cnt_ff, fifo_cnt_in;
   logic [tocr_pkg::OCC_W-1:0]        occ_ff, occ_in;
   logic                              fifo_push;
   logic                              rsp_accept;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_en_ff <= 1'b0;
         first_code_ff <= tocr_pkg::FONT_FIRST_RESET;
         last_code_ff  <= tocr_pkg::FONT_LAST_RESET;
      end else if (csr_wr) begin
         case (tocr_pkg::csr_index_type'(csr_paddr[3:2]))
            tocr_pkg::CSR_OVERLAY_ENABLED: overlay_en_ff <= csr_pwdata[0];
            tocr_pkg::CSR_FONT_FIRST_CODE: first_code_ff <= csr_pwdata[7:0];
            tocr_pkg::CSR_FONT_LAST_CODE:  last_code_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (tocr_pkg::csr_index_type'(csr_paddr[3:2]))
         tocr_pkg::CSR_OVERLAY_ENABLED: csr_prdata = {31'd0, overlay_en_ff};
         tocr_pkg::CSR_FONT_FIRST_CODE: csr_prdata = {24'd0, first_code_ff};
         tocr_pkg::CSR_FONT_LAST_CODE:  csr_prdata = {24'd0, last_code_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- clearing pass
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == CIDX_W'(BUF_CELLS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + CIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------- input, stage 1
   assign req_kind         = tocr_pkg::req_kind_type'(req_tuser);
   assign req_cell_index   = req_tdata[8:0];
   assign req_char_code    = req_tdata[16:9];
   assign req_palette      = req_tdata[18:17];
   assign req_font_address = req_tdata[30:19];
   assign req_font_word    = req_tdata[46:31];
   assign req_line         = req_tdata[54:47];
   assign req_column       = req_tdata[59:55];

   assign req_tready = !clr_busy_ff && (occ_ff < tocr_pkg::OCC_W'(tocr_pkg::FIFO_DEPTH));
   assign req_accept = req_tvalid & req_tready;

   // line / GLYPH_ROWS by reciprocal; exact for every 8-bit line
   assign row_prod  = tocr_pkg::PROD_W'(req_line) * tocr_pkg::PROD_W'(ROW_RECIP);
   assign s1_row_in = row_prod[tocr_pkg::RECIP_SHIFT +: tocr_pkg::ROW_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff         <= req_kind;
      s1_cell_index_ff   <= req_cell_index;
      s1_char_code_ff    <= req_char_code;
      s1_palette_ff      <= req_palette;
      s1_font_address_ff <= req_font_address;
      s1_font_word_ff    <= req_font_word;
      s1_line_ff         <= req_line;
      s1_column_ff       <= req_column;
      s1_row_ff          <= s1_row_in;
   end

   // ---------------------------------------------------------------- stage 2: cell store
   always_comb begin
      render_cell = tocr_pkg::CALC_W'(s1_row_ff) * tocr_pkg::CALC_W'(BUF_COLS)
                  + tocr_pkg::CALC_W'(s1_column_ff);
      row_base    = 8'(tocr_pkg::CALC_W'(s1_row_ff) * tocr_pkg::CALC_W'(GLYPH_ROWS));
      sub_full    = s1_line_ff - row_base;
      s2_sub_in   = sub_full[tocr_pkg::SUB_W-1:0];
      render_ok   = overlay_en_ff
                  && (tocr_pkg::CALC_W'(s1_row_ff) < tocr_pkg::CALC_W'(BUF_ROWS))
                  && (tocr_pkg::CALC_W'(s1_column_ff) < tocr_pkg::CALC_W'(BUF_COLS));
      frame_end_hit = tocr_pkg::CALC_W'(s1_line_ff) == tocr_pkg::CALC_W'(SCREEN_LINES - 1);
      s2_render_ok_in = render_ok;
      s2_fend_in      = frame_end_hit;

      cell_we    = 1'b0;
      cell_re    = 1'b0;
      cell_addr  = render_cell[CIDX_W-1:0];
      cell_wdata = {s1_palette_ff, s1_char_code_ff};
      if (clr_busy_ff) begin
         cell_we    = 1'b1;
         cell_addr  = clr_addr_ff;
         cell_wdata = '0;
      end else if (s1_vld_ff && (s1_kind_ff == tocr_pkg::REQ_CELL_WRITE)) begin
         cell_we   = tocr_pkg::CALC_W'(s1_cell_index_ff) < tocr_pkg::CALC_W'(BUF_CELLS);
         cell_addr = tocr_pkg::CALC_W'(s1_cell_index_ff) < tocr_pkg::CALC_W'(BUF_CELLS)
                   ? CIDX_W'(s1_cell_index_ff) : '0;
      end else if (s1_vld_ff && (s1_kind_ff == tocr_pkg::REQ_RENDER)) begin
         cell_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_ram_ff[cell_addr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_ram_ff[cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff         <= s1_kind_ff;
      s2_font_address_ff <= s1_font_address_ff;
      s2_font_word_ff    <= s1_font_word_ff;
      s2_sub_ff          <= s2_sub_in;
      s2_column_ff       <= s1_column_ff;
      s2_fend_ff         <= s2_fend_in;
      s2_render_ok_ff    <= s2_render_ok_in;
   end

   // ---------------------------------------------------------------- stage 3: font store
   always_comb begin
      cell_code  = cell_rd_ff[tocr_pkg::CODE_W-1:0];
      cell_pal   = cell_rd_ff[tocr_pkg::CELL_DATA_W-1:tocr_pkg::CODE_W];
      code_ok    = (cell_code >= first_code_ff) && (cell_code <= last_code_ff);
      code_off   = cell_code - first_code_ff;
      glyph_addr = tocr_pkg::FADDR_W'(code_off) * tocr_pkg::FADDR_W'(GLYPH_ROWS)
                 + tocr_pkg::FADDR_W'(s2_sub_ff);
      load_addr  = tocr_pkg::FADDR_W'(s2_font_address_ff);
      s3_draw_in = s2_render_ok_ff && code_ok
                 && (glyph_addr < tocr_pkg::FADDR_W'(FONT_WORDS));

      font_we  = s2_vld_ff && (s2_kind_ff == tocr_pkg::REQ_FONT_WRITE)
               && (load_addr < tocr_pkg::FADDR_W'(FONT_WORDS));
      font_re  = s2_vld_ff && (s2_kind_ff == tocr_pkg::REQ_RENDER);
      font_idx = (s2_kind_ff == tocr_pkg::REQ_FONT_WRITE) ? load_addr[FIDX_W-1:0]
                                                          : glyph_addr[FIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (font_we) begin
         font_ram_ff[font_idx] <= s2_font_word_ff;
      end
      if (font_re) begin
         font_rd_ff <= font_ram_ff[font_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_kind_ff   <= s2_kind_ff;
      s3_draw_ff   <= s3_draw_in;
      s3_pal_ff    <= cell_pal;
      s3_column_ff <= s2_column_ff;
      s3_fend_ff   <= s2_fend_ff;
   end

   // ---------------------------------------------------------------- stage 4: colour map
   always_comb begin
      for (int i = 0; i < tocr_pkg::CELL_PIXELS; i++) begin
         mapped_pixels[i*tocr_pkg::COLOUR_W +: tocr_pkg::COLOUR_W] =
            tocr_pkg::COLOUR_TABLE[{s3_pal_ff, font_rd_ff[2*i +: 2]}];
      end

      rsp_item = '0;
      if (s3_kind_ff == tocr_pkg::REQ_RENDER) begin
         rsp_item.draw      = s3_draw_ff;
         rsp_item.pixels    = s3_draw_ff ? mapped_pixels : '0;
         rsp_item.pixel_x   = {s3_column_ff, 3'b000};
         rsp_item.frame_end = s3_fend_ff;
      end
   end

   // ---------------------------------------------------------------- result queue
   assign fifo_push  = s3_vld_ff;
   assign fifo_head  = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {fifo_head.pixel_x, fifo_head.pixels};
   assign rsp_tuser  = fifo_head.draw;
   assign rsp_tlast  = fifo_head.frame_end;

   // occupancy counts items in flight plus queued, so the queue never overflows
   always_comb begin
      wr_ptr_in   = fifo_push ? wr_ptr_ff + tocr_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in   = rsp_accept ? rd_ptr_ff + tocr_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff + tocr_pkg::OCC_W'(fifo_push) - tocr_pkg::OCC_W'(rsp_accept);
      occ_in      = occ_ff + tocr_pkg::OCC_W'(req_accept) - tocr_pkg::OCC_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= rsp_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         occ_ff      <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
         occ_ff      <= occ_in;
      end
   end

endmodule
